FILE: hdl/tcp_timestamp_option_extract_top_macros.svh
// ---------------------------------------------------------------------------
// tcp timestamp option extractor: assertion macros
// clocked, reset-qualified property checks, included by only one of the rtl files
// ---------------------------------------------------------------------------
`ifndef TCP_TIMESTAMP_OPTION_EXTRACT_TOP_MACROS_SVH
`define TCP_TIMESTAMP_OPTION_EXTRACT_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// property checked on every rising edge outside reset
`define TSX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// implication checked on every rising edge outside reset
`define TSX_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define TSX_ASSERT(lbl, prop, msg)
`define TSX_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/tsx_pkg.sv
// ---------------------------------------------------------------------------
// tsx_pkg
// option kinds, lengths, parse phases and the parse state record
// ---------------------------------------------------------------------------
package tsx_pkg;

	// option kinds
	localparam logic [7:0] KIND_NOP     = 8'd1;
	localparam logic [7:0] KIND_MSS     = 8'd2;
	localparam logic [7:0] KIND_WSCALE  = 8'd3;
	localparam logic [7:0] KIND_SACK_OK = 8'd4;
	localparam logic [7:0] KIND_SACK    = 8'd5;
	localparam logic [7:0] KIND_TSTAMP  = 8'd8;

	// option lengths, kind byte included
	localparam logic [7:0] LEN_TSTAMP  = 8'd10;
	localparam logic [7:0] LEN_MSS     = 8'd4;
	localparam logic [7:0] LEN_WSCALE  = 8'd3;
	localparam logic [7:0] LEN_SACK_OK = 8'd2;

	// smallest legal sack length
	localparam logic [7:0] SACK_MIN_LEN = 8'd2;

	// timestamp body: index 0 is the length byte, 1..4 value, 5..8 echo
	localparam logic [3:0] TS_VALUE_FIRST = 4'd1;
	localparam logic [3:0] TS_VALUE_LAST  = 4'd4;
	localparam logic [3:0] TS_BODY_LAST   = 4'(LEN_TSTAMP - 8'd2);

	// parse phases
	localparam logic [2:0] PH_KIND    = 3'd0;
	localparam logic [2:0] PH_SKIP    = 3'd1;
	localparam logic [2:0] PH_SACKLEN = 3'd2;
	localparam logic [2:0] PH_STAMP   = 3'd3;
	localparam logic [2:0] PH_DONE    = 3'd4;

	typedef struct packed {
		logic [2:0]  phase;
		logic [7:0]  skip;
		logic [3:0]  idx;
		logic [31:0] value;
		logic [31:0] echo;
		logic        found;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{
		phase: PH_KIND,
		skip:  8'd0,
		idx:   4'd0,
		value: 32'd0,
		echo:  32'd0,
		found: 1'b0
	};

endpackage

FILE: hdl/tcp_timestamp_option_extract_top.sv
// ---------------------------------------------------------------------------
// tcp_timestamp_option_extract_top
// walks a tcp option area byte by byte and reports the first timestamp
// ---------------------------------------------------------------------------
// usage
//   slave side: one option byte per beat in tdata, tuser marks the first byte
//   of a segment's options, tlast marks the final byte
//   master side: one beat per segment, issued for the input beat with tlast;
//   tuser is the found flag, tdata holds value (low word) and echo (high word),
//   both zero when no complete timestamp option was seen
// throughput and pipeline
//   one input beat per cycle unless a last byte waits for a full output; the
//   result is loaded into the output register from the input register once its
//   last byte there can advance
//   the parse state update is a single small step per byte, taken between the
//   input register and the state/result registers
// reset
//   arst_n clears both valid flags and the parse state; the first byte after
//   reset starts a new segment even without a first mark
// stall
//   a held output stalls only a beat carrying tlast; other bytes keep flowing,
//   and s_axis_tready drops only while a last byte waits for a full output
// ---------------------------------------------------------------------------
module tcp_timestamp_option_extract_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] opt_byte
	input  logic        s_axis_tuser,   // [0] first_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] ts_value, [63:32] ts_echo
	output logic        m_axis_tuser    // [0] ts_found
);
	import tsx_pkg::*;

	`include "tcp_timestamp_option_extract_top_macros.svh"

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        last_s1;

	// result register
	logic        res_valid_s2;
	logic        res_found_s2;
	logic [31:0] res_value_s2;
	logic [31:0] res_echo_s2;

	// parse state
	parse_state_t st_q;
	parse_state_t cur;
	parse_state_t nxt;

	logic out_free;
	logic advance;

	// a byte without tlast never needs the output register
	assign out_free      = !res_valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			first_s1 <= s_axis_tuser;
			last_s1  <= s_axis_tlast;
		end
	end

	// one parse step; a first mark restarts the walk before the byte is taken
	always_comb begin
		cur = first_s1 ? PARSE_RESET : st_q;
		nxt = cur;
		case (cur.phase)
			PH_KIND: begin
				case (byte_s1)
					KIND_MSS: begin
						nxt.skip  = LEN_MSS - 8'd1;
						nxt.phase = PH_SKIP;
					end
					KIND_WSCALE: begin
						nxt.skip  = LEN_WSCALE - 8'd1;
						nxt.phase = PH_SKIP;
					end
					KIND_SACK_OK: begin
						nxt.skip  = LEN_SACK_OK - 8'd1;
						nxt.phase = PH_SKIP;
					end
					KIND_SACK: begin
						nxt.phase = PH_SACKLEN;
					end
					KIND_TSTAMP: begin
						nxt.idx   = 4'd0;
						nxt.value = 32'd0;
						nxt.echo  = 32'd0;
						nxt.phase = PH_STAMP;
					end
					KIND_NOP: begin
						nxt.phase = PH_KIND;
					end
					// end-of-list and unknown kinds take one byte
					default: begin
						nxt.phase = PH_KIND;
					end
				endcase
			end
			PH_SKIP: begin
				nxt.skip = cur.skip - 8'd1;
				if (cur.skip == 8'd1) begin
					nxt.phase = PH_KIND;
				end
			end
			PH_SACKLEN: begin
				if (byte_s1 < SACK_MIN_LEN) begin
					nxt.phase = PH_DONE;
				end else begin
					nxt.skip  = byte_s1 - SACK_MIN_LEN;
					nxt.phase = (byte_s1 == SACK_MIN_LEN) ? PH_KIND : PH_SKIP;
				end
			end
			PH_STAMP: begin
				if (cur.idx >= TS_VALUE_FIRST && cur.idx <= TS_VALUE_LAST) begin
					nxt.value = {cur.value[23:0], byte_s1};
				end else if (cur.idx > TS_VALUE_LAST) begin
					nxt.echo = {cur.echo[23:0], byte_s1};
				end
				nxt.idx = cur.idx + 4'd1;
				if (cur.idx >= TS_BODY_LAST) begin
					nxt.found = 1'b1;
					nxt.phase = PH_DONE;
				end
			end
			// done: remaining bytes are ignored
			default: begin
				nxt = cur;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PARSE_RESET;
		end else if (advance) begin
			st_q <= last_s1 ? PARSE_RESET : nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance && last_s1) begin
			res_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_found_s2 <= nxt.found;
			res_value_s2 <= nxt.found ? nxt.value : 32'd0;
			res_echo_s2  <= nxt.found ? nxt.echo : 32'd0;
		end
	end

	assign m_axis_tvalid = res_valid_s2;
	assign m_axis_tuser  = res_found_s2;
	assign m_axis_tdata  = {res_echo_s2, res_value_s2};

	// checks
	`TSX_ASSERT_IMP(a_notfound_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 64'd0, "not-found result carries nonzero stamps")
	`TSX_ASSERT_IMP(a_skip_nonzero, st_q.phase == PH_SKIP, st_q.skip != 8'd0, "skip phase with nothing left to skip")
	`TSX_ASSERT_IMP(a_idx_bound, st_q.phase == PH_STAMP, st_q.idx <= TS_BODY_LAST, "timestamp body index past its end")
	`TSX_ASSERT_IMP(a_stall_cause, !s_axis_tready, valid_s1 && last_s1 && m_axis_tvalid && !m_axis_tready, "input stalled without a blocked last byte")
	`TSX_ASSERT_IMP(a_found_done, st_q.found, st_q.phase == PH_DONE, "found flag set outside the done phase")

endmodule

FILE: verif/tsx_stamp_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tsx_stamp_checker
// follows the option walk on every accepted byte beat and checks each result
// beat against the stamp owed by the oldest finished segment
// ---------------------------------------------------------------------------
module tsx_stamp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,
	input  logic        m_axis_tuser,
	output int          mismatch_count,
	output int          stamps_pending
);
	import tsx_pkg::*;

	typedef struct {
		logic        found;
		logic [31:0] value;
		logic [31:0] echo;
	} stamp_t;

	stamp_t      owed_stamps[$];
	stamp_t      owed;
	stamp_t      done_stamp;
	int          errors;

	// walk state
	logic [2:0]  walk_phase;
	logic [7:0]  skip_count;
	logic [3:0]  body_idx;
	logic [31:0] value_acc;
	logic [31:0] echo_acc;
	logic        found_seen;

	task automatic clear_walk();
		walk_phase = PH_KIND;
		skip_count = '0;
		body_idx   = '0;
		value_acc  = '0;
		echo_acc   = '0;
		found_seen = 1'b0;
	endtask

	task automatic walk_byte(input logic [7:0] b);
		case (walk_phase)
			PH_KIND: begin
				case (b)
					KIND_MSS: begin
						skip_count = LEN_MSS - 8'd1;
						walk_phase = PH_SKIP;
					end
					KIND_WSCALE: begin
						skip_count = LEN_WSCALE - 8'd1;
						walk_phase = PH_SKIP;
					end
					KIND_SACK_OK: begin
						skip_count = LEN_SACK_OK - 8'd1;
						walk_phase = PH_SKIP;
					end
					KIND_SACK: walk_phase = PH_SACKLEN;
					KIND_TSTAMP: begin
						body_idx   = '0;
						value_acc  = '0;
						echo_acc   = '0;
						walk_phase = PH_STAMP;
					end
					default: ;	// nop, end of list, unknown: one byte
				endcase
			end
			PH_SKIP: begin
				skip_count = skip_count - 8'd1;
				if (skip_count == 8'd0)
					walk_phase = PH_KIND;
			end
			PH_SACKLEN: begin
				if (b < SACK_MIN_LEN) begin
					walk_phase = PH_DONE;
				end else begin
					skip_count = b - SACK_MIN_LEN;
					walk_phase = (skip_count == 8'd0) ? PH_KIND : PH_SKIP;
				end
			end
			PH_STAMP: begin
				// index 0 is the length byte, never checked
				if (body_idx >= TS_VALUE_FIRST && body_idx <= TS_VALUE_LAST)
					value_acc = {value_acc[23:0], b};
				else if (body_idx > TS_VALUE_LAST)
					echo_acc = {echo_acc[23:0], b};
				body_idx = body_idx + 4'd1;
				if (body_idx > TS_BODY_LAST) begin
					found_seen = 1'b1;
					walk_phase = PH_DONE;
				end
			end
			default: ;	// done: rest of the segment ignored
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_walk();
			owed_stamps.delete();
			errors = 0;
		end else begin
			// result side first: a result never belongs to a byte of the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				if (owed_stamps.size() == 0) begin
					$error("result beat with no segment pending");
					errors++;
				end else begin
					owed = owed_stamps.pop_front();
					if (m_axis_tuser !== owed.found) begin
						$error("ts_found: expected %0d, got %0d", owed.found, m_axis_tuser);
						errors++;
					end
					if (m_axis_tdata[31:0] !== owed.value) begin
						$error("ts_value: expected %08h, got %08h", owed.value,
							m_axis_tdata[31:0]);
						errors++;
					end
					if (m_axis_tdata[63:32] !== owed.echo) begin
						$error("ts_echo: expected %08h, got %08h", owed.echo,
							m_axis_tdata[63:32]);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser)
					clear_walk();
				walk_byte(s_axis_tdata);
				if (s_axis_tlast) begin
					done_stamp.found = found_seen;
					done_stamp.value = found_seen ? value_acc : 32'd0;
					done_stamp.echo  = found_seen ? echo_acc : 32'd0;
					owed_stamps.push_back(done_stamp);
					clear_walk();
				end
			end
		end
		mismatch_count <= errors;
		stamps_pending <= owed_stamps.size();
	end

endmodule

FILE: verif/tcp_timestamp_option_extract_top_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tcp_timestamp_option_extract_top_test
// drives option areas byte by byte, mostly well-formed option lists with
// random content, truncations and noise, against a bursty sender and a
// stalling receiver; the checker predicts every result beat
// ---------------------------------------------------------------------------
module tcp_timestamp_option_extract_top_test;
	import tsx_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_RANDOM,
		RX_SPARSE,
		RX_TOGGLE
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;	// [7:0] opt_byte
	logic        s_axis_tuser = 1'b0;	// [0] first_byte
	logic        s_axis_tlast = 1'b0;	// last_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;	// [31:0] ts_value, [63:32] ts_echo
	logic        m_axis_tuser;	// [0] ts_found

	int          mismatch_count;
	int          stamps_pending;
	int          beats_sent = 0;
	int          burst_left = 0;
	rx_mode_t    rx_mode = RX_OPEN;
	int          rx_mode_left = 0;

	// 2 ns period
	always #1 clk = ~clk;

	tcp_timestamp_option_extract_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	tsx_stamp_checker stamp_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.s_axis_tlast   (s_axis_tlast),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.mismatch_count (mismatch_count),
		.stamps_pending (stamps_pending)
	);

	// receiver: each stretch picks a stall pattern, open stretches included
	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode      <= rx_mode_t'($urandom_range(0, 3));
			rx_mode_left <= $urandom_range(20, 200);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		case (rx_mode)
			RX_OPEN:   m_axis_tready <= 1'b1;
			RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
			default:   m_axis_tready <= ~m_axis_tready;
		endcase
	end

	// one byte beat; a gap of random length opens each new burst
	task automatic send_beat(input logic [7:0] b, input logic first, input logic last);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= first;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		beats_sent++;
	endtask

	// a whole option area; tlast on its final byte, an optional stray first
	// mark part way through
	task automatic send_segment(input byte_q_t seg, input logic lead_first,
		input int extra_first);
		for (int i = 0; i < seg.size(); i++)
			send_beat(seg[i], (i == 0) ? lead_first : (i == extra_first),
				i == seg.size() - 1);
	endtask

	// random option list: mostly well-formed, some truncated, some pure noise
	task automatic build_segment(output byte_q_t seg);
		int          n_opts;
		logic [7:0]  len;
		seg = {};
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 24)) seg.push_back(8'($urandom));
			return;
		end
		n_opts = $urandom_range(1, 6);
		repeat (n_opts) begin
			case ($urandom_range(0, 11))
				0: seg.push_back(KIND_NOP);
				1: seg.push_back(8'd0);	// end of list
				2: begin
					seg.push_back(KIND_MSS);
					repeat (3) seg.push_back(8'($urandom));
				end
				3: begin
					seg.push_back(KIND_WSCALE);
					repeat (2) seg.push_back(8'($urandom));
				end
				4: begin
					seg.push_back(KIND_SACK_OK);
					seg.push_back(8'($urandom));
				end
				5, 6: begin
					// sack: usually whole blocks, rarely a bad or very long length
					case ($urandom_range(0, 9))
						0:       len = 8'($urandom_range(0, 1));
						1:       len = 8'($urandom);
						default: len = 8'(2 + 8 * $urandom_range(0, 4));
					endcase
					seg.push_back(KIND_SACK);
					seg.push_back(len);
					if (len >= SACK_MIN_LEN)
						repeat (len - SACK_MIN_LEN) seg.push_back(8'($urandom));
				end
				7, 8, 9: begin
					// timestamp, length byte sometimes bogus
					seg.push_back(KIND_TSTAMP);
					seg.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom)
						: LEN_TSTAMP);
					repeat (8) seg.push_back(8'($urandom));
				end
				default: seg.push_back(8'($urandom_range(6, 255)));	// mostly unknown
			endcase
		end
		// cut short now and then, so options end early
		if ($urandom_range(0, 7) == 0 && seg.size() > 1)
			seg = seg[0:$urandom_range(0, seg.size() - 2)];
	endtask

	initial begin
		byte_q_t seg;
		logic    lead_first;
		int      extra_first;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte option area, first and last together
		seg = {KIND_TSTAMP};
		send_segment(seg, 1'b1, -1);
		// nop then a full timestamp, value all ones and echo all zeros
		seg = {KIND_NOP, KIND_TSTAMP, LEN_TSTAMP,
			8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00};
		send_segment(seg, 1'b1, -1);
		// no first mark; sack length below two stops the walk before a stamp
		seg = {KIND_SACK, 8'd1, KIND_TSTAMP, LEN_TSTAMP,
			8'h12, 8'h34, 8'h56, 8'h78, 8'h9a, 8'hbc, 8'hde, 8'hf0};
		send_segment(seg, 1'b0, -1);
		// every skipped kind, then a timestamp cut off part way
		seg = {KIND_MSS, 8'hff, 8'hff, 8'hff, KIND_WSCALE, 8'h00, 8'h00,
			KIND_SACK_OK, 8'hff, KIND_SACK, 8'd2, 8'hff,
			KIND_TSTAMP, 8'h00, 8'h12};
		send_segment(seg, 1'b1, -1);

		// random part
		while (beats_sent < 1240) begin
			build_segment(seg);
			lead_first  = ($urandom_range(0, 9) != 0);
			extra_first = ($urandom_range(0, 15) == 0 && seg.size() > 2)
				? $urandom_range(1, seg.size() - 1) : -1;
			send_segment(seg, lead_first, extra_first);
		end
		s_axis_tvalid <= 1'b0;

		// drain: wait until every owed result beat has been taken
		@(posedge clk);
		while (stamps_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// hang guard: 1 ms is far beyond the slowest legal run
	initial begin
		#1000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: tcp_timestamp_option_extract_top.f
+incdir+hdl
hdl/tsx_pkg.sv
hdl/tcp_timestamp_option_extract_top.sv
verif/tsx_stamp_checker.sv
verif/tcp_timestamp_option_extract_top_test.sv
